// ===== src/range_set_membership_table_top_defines.svh =====
// ----------------------------------------------------------------------------
// range set membership table: assertion macros
// checks are compiled in unless SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef RANGE_SET_MEMBERSHIP_TABLE_TOP_DEFINES_SVH
`define RANGE_SET_MEMBERSHIP_TABLE_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define RSMT_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, sampled on clk, off during reset
`define RSMT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RSMT_ASSERT_IMPL(label, ante, cons, msg)
`define RSMT_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== src/rsmt_pkg.sv =====
// ----------------------------------------------------------------------------
// rsmt_pkg
// shared types, request codes and the fixed exclusion ranges
// ----------------------------------------------------------------------------
package rsmt_pkg;

	localparam int CP_W           = 21;
	localparam int USED_W         = 7;
	localparam int MAX_RANGES_DEF = 64;

	// request kinds carried in tuser
	localparam logic [1:0] REQ_QUERY = 2'd0;
	localparam logic [1:0] REQ_INCL  = 2'd1;
	localparam logic [1:0] REQ_EXCL  = 2'd2;
	localparam logic [1:0] REQ_UNI   = 2'd3;

	// surrogates, private use area, supplementary private use a and b
	localparam logic [CP_W-1:0] EXCL_LO [4] = '{21'h00D800, 21'h00E000, 21'h0F0000, 21'h100000};
	localparam logic [CP_W-1:0] EXCL_HI [4] = '{21'h00DFFF, 21'h00F8FF, 21'h0FFFFF, 21'h10FFFF};

	typedef struct packed {
		logic [CP_W-1:0] lo;
		logic [CP_W-1:0] hi;
		logic            inc;
	} entry_t;

	typedef struct packed {
		logic clear;
		logic valid;
	} acc_ctl_t;

endpackage

// ===== src/rsmt_mem.sv =====
// ----------------------------------------------------------------------------
// rsmt_mem
// range entry storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module rsmt_mem #(
	parameter int MAX_RANGES = rsmt_pkg::MAX_RANGES_DEF,
	parameter int ADDR_W     = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [ADDR_W-1:0]    wr_addr,
	input  rsmt_pkg::entry_t     wr_data,
	input  logic                 rd_en,
	input  logic [ADDR_W-1:0]    rd_addr,
	output rsmt_pkg::entry_t     rd_data
);
	import rsmt_pkg::*;

	entry_t mem_q [MAX_RANGES];
	entry_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/rsmt_acc.sv =====
// ----------------------------------------------------------------------------
// rsmt_acc
// shared range compare and weight accumulator, one entry per cycle
// ----------------------------------------------------------------------------
module rsmt_acc #(
	parameter int MAX_RANGES = rsmt_pkg::MAX_RANGES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rsmt_pkg::acc_ctl_t        ctl,
	input  logic [rsmt_pkg::CP_W-1:0] cp,
	input  rsmt_pkg::entry_t          entry,
	output logic                      member
);
	import rsmt_pkg::*;

	localparam int SUM_W = $clog2(MAX_RANGES + 1) + 1;

	logic [SUM_W-1:0] sum_q;
	logic             hit;
	logic [SUM_W-1:0] step;

	// inclusive range compare
	assign hit  = (cp >= entry.lo) && (cp <= entry.hi);
	assign step = entry.inc ? SUM_W'(1) : {SUM_W{1'b1}};

	// two's complement weight sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.clear) begin
			sum_q <= '0;
		end else if (ctl.valid && hit) begin
			sum_q <= sum_q + step;
		end
	end

	// positive means member
	assign member = !sum_q[SUM_W-1] && (sum_q != '0);

endmodule

// ===== src/range_set_membership_table_top.sv =====
// ----------------------------------------------------------------------------
// range_set_membership_table_top
// ordered table of include and exclude code point ranges with queries
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream group, one word per request, with the
// request kind in s_tuser (0 query, 1 include, 2 exclude, 3 unicode
// exclusions). Each request gives exactly one result word on the m_ group.
// An include or exclude is written to the table as it is accepted, the
// unicode exclusions append the four fixed exclusion ranges in turn, and
// a query walks every stored entry through one shared compare unit, one
// memory read per cycle, then a drain state, before the result goes to the
// output register. s_tready is high only while the sequencer is idle, so
// one request is in work at a time, and the next one is taken once the
// result is handed on.
// Results land in an output register; the next request is taken while a
// result waits there, and if the receiver stalls, a finished result is held
// in the sequencer until the output register is free.
// Reset clears the entry count and the control state; table contents are
// not cleared, since entries at or above the count are never read.
// ----------------------------------------------------------------------------
module range_set_membership_table_top #(
	parameter int MAX_RANGES = rsmt_pkg::MAX_RANGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// range_start [20:0], range_end [41:21], code_point [62:42], zero pad
	input  logic [63:0] s_tdata,
	// req_type [1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// is_member [0], append_dropped [1], entries_used [8:2], zero pad
	output logic [15:0] m_tdata
);
	import rsmt_pkg::*;

	`include "range_set_membership_table_top_defines.svh"

	localparam int CNT_W  = $clog2(MAX_RANGES + 1);
	localparam int ADDR_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RANGES);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_QUERY  = 3'd1;
	localparam logic [2:0] ST_DRAIN  = 3'd2;
	localparam logic [2:0] ST_EXCL   = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic [1:0]       k_q;
	logic [CP_W-1:0]  cp_q;
	logic             drop_q;
	logic             member_q;
	logic             vld_s1;
	logic             m_tvalid_q;
	logic [15:0]      m_tdata_q;

	logic [1:0]       s_req;
	logic [CP_W-1:0]  s_lo;
	logic [CP_W-1:0]  s_hi;
	logic [CP_W-1:0]  s_cp;
	logic             accept;
	logic             has_room;
	logic             out_free;
	logic             wr_en;
	entry_t           wr_data;
	logic             rd_en;
	entry_t           rd_data;
	acc_ctl_t         acc_ctl;
	logic             acc_member;
	logic [CNT_W+USED_W-1:0] used_ext;

	// unpack the request word
	assign s_req = s_tuser;
	assign s_lo  = s_tdata[CP_W-1:0];
	assign s_hi  = s_tdata[2*CP_W-1:CP_W];
	assign s_cp  = s_tdata[3*CP_W-1:2*CP_W];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign has_room = (count_q < MAX_CNT);
	assign out_free = !m_tvalid_q || m_tready;

	// table write and read control
	always_comb begin
		wr_en   = 1'b0;
		wr_data = '{lo: s_lo, hi: s_hi, inc: (s_req == REQ_INCL)};
		if (state_q == ST_EXCL) begin
			wr_en   = has_room;
			wr_data = '{lo: EXCL_LO[k_q], hi: EXCL_HI[k_q], inc: 1'b0};
		end else if (accept && (s_req inside {REQ_INCL, REQ_EXCL})) begin
			wr_en = has_room;
		end
	end

	assign rd_en = (state_q == ST_QUERY) && (idx_q != count_q);

	assign acc_ctl = '{clear: accept && (s_req == REQ_QUERY), valid: vld_s1};

	rsmt_mem #(
		.MAX_RANGES(MAX_RANGES),
		.ADDR_W    (ADDR_W)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(count_q[ADDR_W-1:0]),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(idx_q[ADDR_W-1:0]),
		.rd_data(rd_data)
	);

	rsmt_acc #(
		.MAX_RANGES(MAX_RANGES)
	) u_acc (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (acc_ctl),
		.cp    (cp_q),
		.entry (rd_data),
		.member(acc_member)
	);

	// read data is valid in the cycle after the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// request payload, held for the request in work
	always_ff @(posedge clk) begin
		if (accept) begin
			cp_q <= s_cp;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			k_q      <= '0;
			drop_q   <= 1'b0;
			member_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						member_q <= 1'b0;
						drop_q   <= 1'b0;
						idx_q    <= '0;
						k_q      <= '0;
						case (s_req)
							REQ_QUERY: state_q <= ST_QUERY;
							REQ_UNI:   state_q <= ST_EXCL;
							default: begin
								drop_q  <= !has_room;
								state_q <= ST_FINISH;
							end
						endcase
					end
				end
				ST_QUERY: begin
					if (idx_q != count_q) begin
						idx_q <= idx_q + CNT_W'(1);
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					member_q <= acc_member;
					state_q  <= ST_FINISH;
				end
				ST_EXCL: begin
					if (!has_room) begin
						drop_q <= 1'b1;
					end
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// low bits of the count, zero extended for small tables
	assign used_ext = {{USED_W{1'b0}}, count_q};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			m_tdata_q <= {7'd0, used_ext[USED_W-1:0], drop_q, member_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// checks
	`RSMT_ASSERT_IMPL(a_count_max, 1'b1, count_q <= MAX_CNT, "entry count above table depth")
	`RSMT_ASSERT_IMPL(a_rd_in_query, vld_s1, state_q == ST_QUERY, "read data outside a query walk")
	`RSMT_ASSERT_NEXT(a_query_no_write, state_q == ST_QUERY, $stable(count_q), "table written")

endmodule
